// ===== sv/aksq_pkg.sv =====
// Shared types and constants for the Alt keypad code key sequencer.
package aksq_pkg;

  localparam int unsigned CODE_W   = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned DIGITS   = 5;
  localparam int unsigned CFG_IDX_W = 8;

  // register indexes on the config channel
  localparam logic [CFG_IDX_W-1:0] CFG_ALT_MOD   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_MOD = 8'd1;

  localparam logic [BYTE_W-1:0] ALT_MOD_RST   = 8'h40;
  localparam logic [BYTE_W-1:0] SHIFT_MOD_RST = 8'h20;

  // keypad usage codes
  localparam logic [BYTE_W-1:0] KEYPAD_ZERO = 8'd98;
  localparam logic [BYTE_W-1:0] KEYPAD_BASE = 8'd88;

  // divide by ten: q = (v * 52429) >> 19, exact for v < 81920
  localparam logic [CODE_W-1:0] RECIP10     = 16'd52429;
  localparam int unsigned       RECIP_SHIFT = 19;

  // positions of the last report word in a run
  localparam logic [3:0] IDX_DIRECT_LAST = 4'd1;
  localparam logic [3:0] IDX_ALT_LAST    = 4'd11;

  typedef struct packed {
    logic                          alt;   // keypad sequence vs direct key
    logic [BYTE_W-1:0]             lo;    // low byte for direct keys
    logic [DIGITS-1:0][DIGIT_W-1:0] dig;  // dig[0] is the most significant
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

endpackage

// ===== sv/alt_code_key_sequencer.sv =====
// Top level: character code in, keyboard report words out.
//
//  channel   dir  handshake                    payload
//  --------  ---  ---------------------------  -------------------------------
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata[15:0] char_code
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata[7:0] modifier_byte,
//                                              tdata[15:8] key_code, tlast
//  cfg       in   cfg_valid_i/cfg_ready_o      index 0 alt_modifier,
//                                              index 1 shift_modifier
//
// Flow: one report word per cycle while m_axis_tready is high and the queue
//   holds a code; a keypad code gives 12 words, a direct key 2, a zero code
//   none. A keypad code goes through four divide-by-ten steps in the front
//   end, one per cycle, a direct key through none, then it waits in the
//   queue; a zero code is dropped at acceptance.
// Sustained rate is set by the report sequencer.
// Reset clears all control state; modifiers return to 0x40 and 0x20.
// Stalls: the output register holds its word under back pressure; the
//   queue lets the front end keep splitting the next code meanwhile.
module alt_code_key_sequencer
  import aksq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input codes
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [15:0]          s_axis_tdata,   // [15:0] char_code
  // report words
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata,   // [7:0] modifier_byte, [15:8] key_code
  output logic                 m_axis_tlast,
  // register writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BYTE_W-1:0]    cfg_data_i
);

  logic [BYTE_W-1:0] alt_mod_q, alt_mod_d;
  logic [BYTE_W-1:0] shift_mod_q, shift_mod_d;

  logic         push, pop;
  entry_t       push_entry, head;
  fifo_status_t q_status;

  // config registers; writes to unknown indexes fall through
  assign cfg_ready_o = 1'b1;

  always_comb begin
    alt_mod_d   = alt_mod_q;
    shift_mod_d = shift_mod_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ALT_MOD:   alt_mod_d   = cfg_data_i;
        CFG_SHIFT_MOD: shift_mod_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alt_mod_q   <= ALT_MOD_RST;
      shift_mod_q <= SHIFT_MOD_RST;
    end else begin
      alt_mod_q   <= alt_mod_d;
      shift_mod_q <= shift_mod_d;
    end
  end

  aksq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_code_i    (s_axis_tdata),
    .q_full_i     (q_status.full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  aksq_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .status_o     (q_status)
  );

  aksq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_empty_i   (q_status.empty),
    .pop_o       (pop),
    .alt_mod_i   (alt_mod_q),
    .shift_mod_i (shift_mod_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_mod_o   (m_axis_tdata[7:0]),
    .out_key_o   (m_axis_tdata[15:8]),
    .out_last_o  (m_axis_tlast)
  );

  // every run ends on an all-zero report
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == '0))
    else $error("last report of a run is not all zero");

  // front end never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full)
    else $error("push into full queue");

  // sequencer never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

  // a popped entry always ends with a final word in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (m_axis_tvalid && m_axis_tlast))
    else $error("pop without final report");

endmodule

// ===== sv/aksq_front.sv =====
// Front end: takes character codes, classifies them and splits keypad codes into digits.
module aksq_front
  import aksq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CODE_W-1:0] in_code_i,
  input  logic              q_full_i,
  output logic              push_o,
  output entry_t            push_entry_o
);

  logic                           busy_q, busy_d;
  logic                           alt_q, alt_d;
  logic [BYTE_W-1:0]              lo_q, lo_d;
  logic [CODE_W-1:0]              val_q, val_d;
  logic [2:0]                     cnt_q, cnt_d;
  logic [DIGITS-1:0][DIGIT_W-1:0] dig_q, dig_d;

  logic [2*CODE_W-1:0] prod;
  logic [12:0]         quot;
  logic [CODE_W-1:0]   quot10;
  logic [CODE_W-1:0]   rem;
  logic                accept;

  // one decimal digit per cycle, least significant first
  assign prod   = {{CODE_W{1'b0}}, val_q} * {{CODE_W{1'b0}}, RECIP10};
  assign quot   = prod[2*CODE_W-1:RECIP_SHIFT];
  assign quot10 = ({3'b000, quot} << 3) + ({3'b000, quot} << 1);
  assign rem    = val_q - quot10;

  assign push_o     = busy_q && (cnt_q == 3'd0) && !q_full_i;
  assign in_ready_o = !busy_q || push_o;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    push_entry_o.alt = alt_q;
    push_entry_o.lo  = lo_q;
    push_entry_o.dig = dig_q;
    // remaining quotient is the top digit
    push_entry_o.dig[0] = val_q[DIGIT_W-1:0];
  end

  always_comb begin
    busy_d = busy_q;
    alt_d  = alt_q;
    lo_d   = lo_q;
    val_d  = val_q;
    cnt_d  = cnt_q;
    dig_d  = dig_q;
    if (busy_q && (cnt_q != 3'd0)) begin
      dig_d[cnt_q] = rem[DIGIT_W-1:0];
      val_d        = {3'b000, quot};
      cnt_d        = cnt_q - 3'd1;
    end
    if (push_o) begin
      busy_d = 1'b0;
    end
    if (accept) begin
      lo_d  = in_code_i[BYTE_W-1:0];
      val_d = in_code_i;
      if (in_code_i == '0) begin
        busy_d = 1'b0;                 // zero code: nothing to type
      end else if (in_code_i[CODE_W-1:BYTE_W] == '0) begin
        busy_d = 1'b1;
        alt_d  = 1'b0;
        cnt_d  = 3'd0;
      end else begin
        busy_d = 1'b1;
        alt_d  = 1'b1;
        cnt_d  = 3'(DIGITS - 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    alt_q <= alt_d;
    lo_q  <= lo_d;
    val_q <= val_d;
    dig_q <= dig_d;
  end

endmodule

// ===== sv/aksq_fifo.sv =====
// Short queue of classified codes between front end and report sequencer.
module aksq_fifo
  import aksq_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  entry_t       push_entry_i,
  input  logic         pop_i,
  output entry_t       head_o,
  output fifo_status_t status_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t          mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q, count_d;

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == CW'(DEPTH));
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ===== sv/aksq_back.sv =====
// Back end: walks one queued code through its reports into the output register.
module aksq_back
  import aksq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  entry_t            head_i,
  input  logic              q_empty_i,
  output logic              pop_o,
  input  logic [BYTE_W-1:0] alt_mod_i,
  input  logic [BYTE_W-1:0] shift_mod_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] out_mod_o,
  output logic [BYTE_W-1:0] out_key_o,
  output logic              out_last_o
);

  logic [3:0]         idx_q, idx_d;
  logic               vld_q, vld_d;
  logic [BYTE_W-1:0]  mod_q, key_q;
  logic               last_q;

  logic [BYTE_W-1:0]  gen_mod, gen_key;
  logic               gen_last;
  logic [DIGIT_W-1:0] digit;
  logic               load;

  // odd positions of a keypad run press digit idx/2
  always_comb begin
    case (idx_q[3:1])
      3'd0:    digit = head_i.dig[0];
      3'd1:    digit = head_i.dig[1];
      3'd2:    digit = head_i.dig[2];
      3'd3:    digit = head_i.dig[3];
      3'd4:    digit = head_i.dig[4];
      default: digit = '0;
    endcase
  end

  always_comb begin
    gen_mod  = '0;
    gen_key  = '0;
    gen_last = 1'b0;
    if (!head_i.alt) begin
      if (idx_q == 4'd0) begin
        gen_mod = head_i.lo[BYTE_W-1] ? shift_mod_i : '0;
        gen_key = {1'b0, head_i.lo[BYTE_W-2:0]};
      end else begin
        gen_last = 1'b1;
      end
    end else if (idx_q == IDX_ALT_LAST) begin
      gen_last = 1'b1;
    end else begin
      gen_mod = alt_mod_i;
      if (idx_q[0]) begin
        gen_key = (digit == '0) ? KEYPAD_ZERO : KEYPAD_BASE + {4'b0000, digit};
      end
    end
  end

  assign load  = !q_empty_i && (!vld_q || out_ready_i);
  assign pop_o = load && gen_last;

  always_comb begin
    idx_d = idx_q;
    vld_d = vld_q;
    if (out_ready_i) begin
      vld_d = 1'b0;
    end
    if (load) begin
      vld_d = 1'b1;
      idx_d = gen_last ? 4'd0 : idx_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 4'd0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mod_q  <= gen_mod;
      key_q  <= gen_key;
      last_q <= gen_last;
    end
  end

  assign out_valid_o = vld_q;
  assign out_mod_o   = mod_q;
  assign out_key_o   = key_q;
  assign out_last_o  = last_q;

endmodule

// ===== tb/sv/aksq_report_checker.sv =====
// Scoreboard for the Alt keypad code key sequencer: predicts report words and compares them.
`timescale 1ns / 100ps

module aksq_report_checker
  import aksq_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 code_valid_i,
  input  logic                 code_ready_i,
  input  logic [CODE_W-1:0]    code_i,
  input  logic                 word_valid_i,
  input  logic                 word_ready_i,
  input  logic [15:0]          word_i,        // [7:0] modifier_byte, [15:8] key_code
  input  logic                 word_last_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BYTE_W-1:0]    cfg_data_i,
  output int                   errors_o,
  output int                   pending_o,
  output int                   codes_o,
  output int                   words_o
);

  typedef struct packed {
    logic [BYTE_W-1:0] modifier;
    logic [BYTE_W-1:0] key;
    logic              last;
  } report_t;

  report_t           report_q[$];
  logic [BYTE_W-1:0] alt_mod;
  logic [BYTE_W-1:0] shift_mod;
  int                errors;
  int                codes;
  int                words;

  // Push the run of reports that one character code should produce.
  function automatic void predict_reports(input logic [CODE_W-1:0] code);
    report_t           run[$];
    int unsigned       rest;
    logic [3:0]        digit [DIGITS];
    logic [BYTE_W-1:0] pressed;
    logic [BYTE_W-1:0] lo;
    lo = code[7:0];
    if (code[15:8] == '0) begin
      if (lo == '0) return;
      // direct key: bit 7 picks shift, keycode is the low seven bits
      run.push_back('{lo[7] ? shift_mod : '0, {1'b0, lo[6:0]}, 1'b0});
      run.push_back('{'0, '0, 1'b0});
    end else begin
      rest = code;
      for (int i = DIGITS - 1; i >= 0; i--) begin
        digit[i] = 4'(rest % 10);
        rest     = rest / 10;
      end
      run.push_back('{alt_mod, '0, 1'b0});
      for (int i = 0; i < DIGITS; i++) begin
        pressed = (digit[i] == 0) ? KEYPAD_ZERO : KEYPAD_BASE + BYTE_W'(digit[i]);
        run.push_back('{alt_mod, pressed, 1'b0});
        run.push_back('{alt_mod, '0, 1'b0});
      end
      run.push_back('{'0, '0, 1'b0});
    end
    run[run.size()-1].last = 1'b1;
    foreach (run[i]) report_q.push_back(run[i]);
  endfunction

  function automatic void check_word(input logic [15:0] data, input logic last);
    report_t want;
    if (report_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: unexpected word mod=%02h key=%02h last=%0b",
                 $realtime, data[7:0], data[15:8], last);
      return;
    end
    want = report_q.pop_front();
    if (data[7:0] !== want.modifier || data[15:8] !== want.key || last !== want.last) begin
      errors++;
      if (errors <= 10)
        $display("%0t: word %0d expected mod=%02h key=%02h last=%0b, got mod=%02h key=%02h last=%0b",
                 $realtime, words, want.modifier, want.key, want.last,
                 data[7:0], data[15:8], last);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_q.delete();
      alt_mod   = ALT_MOD_RST;
      shift_mod = SHIFT_MOD_RST;
      errors    = 0;
      codes     = 0;
      words     = 0;
    end else begin
      if (word_valid_i && word_ready_i) begin
        check_word(word_i, word_last_i);
        words++;
      end
      if (code_valid_i && code_ready_i) begin
        predict_reports(code_i);
        codes++;
      end
      // writes to indexes beyond the register list are dropped
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_ALT_MOD) alt_mod = cfg_data_i;
        else if (cfg_index_i == CFG_SHIFT_MOD) shift_mod = cfg_data_i;
      end
    end
    errors_o  <= errors;
    pending_o <= report_q.size();
    codes_o   <= codes;
    words_o   <= words;
  end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top: drives codes, register writes and back pressure, then reports the verdict.
`timescale 1ns / 100ps

module tb;
  import aksq_pkg::*;

  // indexes outside the register list; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP   = 8'hFF;

  // wait this long after the last expected word has gone before a register write
  localparam int DRAIN_CYCLES = 32;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata = '0;     // [15:0] char_code
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [15:0]          m_axis_tdata;          // [7:0] modifier_byte, [15:8] key_code
  logic                 m_axis_tlast;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [BYTE_W-1:0]    cfg_data_i = '0;

  int errors;
  int pending;
  int codes;
  int words;
  int reg_writes = 0;
  int settings = 1;

  // sink-side stall state, owned by the ready driver below
  int  stall_left = 0;
  int  mode_left  = 0;
  bit  stalling   = 1'b0;

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  alt_code_key_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  aksq_report_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .code_valid_i (s_axis_tvalid),
    .code_ready_i (s_axis_tready),
    .code_i       (s_axis_tdata),
    .word_valid_i (m_axis_tvalid),
    .word_ready_i (m_axis_tready),
    .word_i       (m_axis_tdata),
    .word_last_i  (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .errors_o     (errors),
    .pending_o    (pending),
    .codes_o      (codes),
    .words_o      (words)
  );

  // Gap length: mostly none or short, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Back pressure on the report side. Alternates between stretches of
  // steady ready and stretches of random stalls so gaps land on every
  // position of a 2- or 12-word run.
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stalling  = $urandom_range(2) != 0;
      mode_left = $urandom_range(300, 60);
    end else begin
      mode_left--;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (stalling && $urandom_range(9) < 3) begin
      stall_left = gap_len();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Mix of zero codes, direct keys and keypad codes.
  function automatic logic [15:0] rand_code();
    case ($urandom_range(15))
      0:          return '0;
      1, 2, 3, 4: return {8'h00, 8'($urandom_range(255))};
      5:          return 16'hFFFF;
      default:    return 16'($urandom_range(65535));
    endcase
  endfunction

  // Offer one code; valid stays up when the next word follows without a gap.
  task automatic send_code(input logic [15:0] code, input bit quiet);
    int gap;
    gap = quiet ? 0 : gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= code;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop valid, let all expected words drain, then wait a further DRAIN_CYCLES.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    reg_writes++;
    @(posedge clk_i);
  endtask

  task automatic run_random(input int n, input bit quiet);
    repeat (n) send_code(rand_code(), quiet);
    drain();
  endtask

  initial begin
    // zero code, direct key extremes including the bare shift bit,
    // smallest and largest keypad codes, and codes touching every digit
    static logic [15:0] directed_q[$] = '{
      16'h0000, 16'h0001, 16'h007F, 16'h0080, 16'h00FF, 16'h0081, 16'h0000,
      16'h0100, 16'hFFFF, 16'd10000, 16'd12345, 16'd60789, 16'h0000, 16'h0155,
      16'd9999, 16'hFF00
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset modifiers
    foreach (directed_q[i]) send_code(directed_q[i], 1'b0);
    drain();

    // one extreme setting, pushed with no source gaps
    write_reg(CFG_ALT_MOD, 8'hFF);
    write_reg(CFG_SHIFT_MOD, 8'h00);
    settings++;
    run_random(26, 1'b1);

    // the opposite extreme
    write_reg(CFG_ALT_MOD, 8'h00);
    write_reg(CFG_SHIFT_MOD, 8'hFF);
    settings++;
    run_random(26, 1'b0);

    // writes to unmapped indexes must leave both modifiers alone
    write_reg(CFG_IDX_SPARE, 8'hAA);
    write_reg(CFG_IDX_TOP, 8'h55);
    run_random(26, 1'b0);

    // arbitrary values
    write_reg(CFG_ALT_MOD, 8'($urandom_range(255)));
    write_reg(CFG_SHIFT_MOD, 8'($urandom_range(255)));
    settings++;
    run_random(26, $urandom_range(1) != 0);

    $display("ran %0d codes through %0d modifier settings, %0d register writes",
             codes, settings, reg_writes);
    $display("checked %0d report words under random source gaps and sink stalls", words);
    // leftover expectations count as failures
    if (errors == 0 && pending == 0) begin
      $display("alt_code_key_sequencer: match");
    end else begin
      $display("alt_code_key_sequencer: mismatch");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("timeout with %0d words still expected", pending);
    $display("alt_code_key_sequencer: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/aksq_pkg.sv
sv/aksq_front.sv
sv/aksq_fifo.sv
sv/aksq_back.sv
sv/alt_code_key_sequencer.sv
tb/sv/aksq_report_checker.sv
tb/sv/tb.sv
